// ----- hdl/multichannel_iir_filter_assert.svh -----
// assertion macros shared by the iir filter modules
`ifndef MULTICHANNEL_IIR_FILTER_ASSERT_SVH
`define MULTICHANNEL_IIR_FILTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IIRF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iir filter check failed");

// next-cycle implication, checked outside reset
`define IIRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iir filter check failed");

`endif

// ----- hdl/iirf_pkg.sv -----
// shared constants, codes and types of the multichannel iir filter
package iirf_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    // seven products need three guard bits
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_BITS  = 28;
    localparam int CH_W       = 4;
    localparam int ORDER_W    = 2;
    localparam int TERM_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_CHANNELS  = 16;
    localparam int DEF_MAX_ORDER = 3;

    // item commands
    localparam logic CMD_FILTER  = 1'b0;
    localparam logic CMD_PRELOAD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B3    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_A1    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_A2    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_A3    = 3'd7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // sequencer controls for the shared multiply-accumulate unit
    typedef struct packed {
        logic issue;
        logic first;
        logic sub;
    } mac_ctrl_t;

endpackage

// ----- hdl/iirf_mac.sv -----
// shared multiply-accumulate unit: registered product, then wide accumulate
module iirf_mac
(
    input  logic                clk,
    input  logic                rst_n,
    input  iirf_pkg::mac_ctrl_t ctrl,
    input  iirf_pkg::sample_t   op_a,
    input  iirf_pkg::coef_t     op_b,
    output iirf_pkg::acc_t      acc
);

    logic signed [iirf_pkg::PROD_W-1:0] prod_reg;
    logic                               prod_vld_reg;
    logic                               prod_first_reg;
    logic                               prod_sub_reg;
    iirf_pkg::acc_t                     acc_reg;
    iirf_pkg::acc_t                     acc_next;
    iirf_pkg::acc_t                     acc_base;
    iirf_pkg::acc_t                     prod_ext;

    // product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg   <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_sub_reg   <= 1'b0;
        end
        else
        begin
            prod_vld_reg   <= ctrl.issue;
            prod_first_reg <= ctrl.first;
            prod_sub_reg   <= ctrl.sub;
        end
    end

    // one 32x32 signed multiply per cycle while ctrl.issue is high
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    // accumulate or subtract the registered product
    always_comb
    begin
        prod_ext = iirf_pkg::ACC_W'(prod_reg);
        acc_base = prod_first_reg ? '0 : acc_reg;
        acc_next = prod_sub_reg ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end

    always_ff @(posedge clk)
    begin
        if (prod_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- hdl/iirf_hist.sv -----
// per-channel input and output history rows with row valid bits
module iirf_hist
#(
    parameter int CHANNELS  = iirf_pkg::DEF_CHANNELS,
    parameter int MAX_ORDER = iirf_pkg::DEF_MAX_ORDER
)
(
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               rd_en,
    input  logic [((CHANNELS < (1 << iirf_pkg::CH_W) ? CHANNELS
                   : (1 << iirf_pkg::CH_W)) > 1
                  ? $clog2(CHANNELS < (1 << iirf_pkg::CH_W) ? CHANNELS
                   : (1 << iirf_pkg::CH_W)) : 1)-1:0]          rd_addr,
    output logic [MAX_ORDER*iirf_pkg::SAMPLE_W-1:0]            rd_x,
    output logic [MAX_ORDER*iirf_pkg::SAMPLE_W-1:0]            rd_y,
    input  logic                                               wr_en,
    input  logic [((CHANNELS < (1 << iirf_pkg::CH_W) ? CHANNELS
                   : (1 << iirf_pkg::CH_W)) > 1
                  ? $clog2(CHANNELS < (1 << iirf_pkg::CH_W) ? CHANNELS
                   : (1 << iirf_pkg::CH_W)) : 1)-1:0]          wr_addr,
    input  logic [MAX_ORDER*iirf_pkg::SAMPLE_W-1:0]            wr_x,
    input  logic [MAX_ORDER*iirf_pkg::SAMPLE_W-1:0]            wr_y
);

    // only channels reachable through the channel field get a row
    localparam int ROWS  = (CHANNELS < (1 << iirf_pkg::CH_W)) ? CHANNELS
                           : (1 << iirf_pkg::CH_W);
    localparam int ROW_W = MAX_ORDER * iirf_pkg::SAMPLE_W;

    logic [ROW_W-1:0] x_mem_reg [ROWS];
    logic [ROW_W-1:0] y_mem_reg [ROWS];
    logic [ROWS-1:0]  row_vld_reg;
    logic [ROW_W-1:0] rd_x_reg;
    logic [ROW_W-1:0] rd_y_reg;
    logic             rd_vld_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem_reg[wr_addr] <= wr_x;
            y_mem_reg[wr_addr] <= wr_y;
        end
        if (rd_en)
        begin
            rd_x_reg <= x_mem_reg[rd_addr];
            rd_y_reg <= y_mem_reg[rd_addr];
        end
    end

    // row valid bits, cleared at reset so untouched rows read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    assign rd_x = rd_vld_reg ? rd_x_reg : '0;
    assign rd_y = rd_vld_reg ? rd_y_reg : '0;

endmodule

// ----- hdl/multichannel_iir_filter.sv -----
// multichannel direct form i iir filter, top level with item sequencer
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | command, channel, sample, preload_output
//  output   | out_valid/out_stall | out_channel, filtered, saturated
//  config   | cfg_we              | cfg_index, cfg_data
//
// at order n > 0 a filter transfer has the one shared 32x32 multiplier compute
// 2n+1 products, one per cycle, then a drain and a round/saturate step;
// pass-through goes straight to done, preload and out-of-range channels end
// at the transfer. reset clears control state, config and the history row
// valid bits at once; no clearing pass. a stalled output holds the result in
// the done state; the input stalls whenever the sequencer is busy.

`include "multichannel_iir_filter_assert.svh"

module multichannel_iir_filter
#(
    parameter int CHANNELS  = iirf_pkg::DEF_CHANNELS,
    parameter int MAX_ORDER = iirf_pkg::DEF_MAX_ORDER
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [iirf_pkg::CH_W-1:0]          channel,
    input  logic signed [iirf_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [iirf_pkg::SAMPLE_W-1:0] preload_output,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [iirf_pkg::CH_W-1:0]          out_channel,
    output logic signed [iirf_pkg::SAMPLE_W-1:0] filtered,
    output logic                               saturated,
    input  logic                               cfg_we,
    input  logic [iirf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iirf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ROWS   = (CHANNELS < (1 << iirf_pkg::CH_W)) ? CHANNELS
                            : (1 << iirf_pkg::CH_W);
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_W  = MAX_ORDER * iirf_pkg::SAMPLE_W;
    localparam int SW     = iirf_pkg::SAMPLE_W;
    localparam int FB     = iirf_pkg::FRAC_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // configuration registers
    logic [iirf_pkg::ORDER_W-1:0] order_reg;
    iirf_pkg::coef_t              coef_b_reg [4];
    iirf_pkg::coef_t              coef_a_reg [3];

    // sequencer and item registers
    logic [1:0]                   state_reg, state_next;
    logic [iirf_pkg::TERM_W-1:0]  term_reg, term_next;
    logic [iirf_pkg::ORDER_W-1:0] n_reg, n_next;
    logic                         pass_reg, pass_next;
    logic [iirf_pkg::CH_W-1:0]    ch_reg;
    iirf_pkg::sample_t            x_reg;

    // output register
    logic                         out_valid_reg;
    logic [iirf_pkg::CH_W-1:0]    out_channel_reg;
    iirf_pkg::sample_t            filtered_reg;
    logic                         saturated_reg;

    logic                         accept;
    logic                         in_range;
    logic                         out_free;
    logic [iirf_pkg::ORDER_W-1:0] n_use;
    logic [ROW_W-1:0]             hist_x, hist_y;
    logic                         wr_en;
    logic [ROW_AW-1:0]            wr_addr;
    logic [ROW_W-1:0]             wr_x, wr_y;
    logic [ROW_W-1:0]             shift_x, shift_y;
    iirf_pkg::mac_ctrl_t          mac_ctrl;
    iirf_pkg::sample_t            op_a;
    iirf_pkg::coef_t              op_b;
    iirf_pkg::acc_t               acc;
    logic [iirf_pkg::TERM_W-1:0]  term_m1;
    logic [1:0]                   tap;
    logic signed [iirf_pkg::ACC_W-FB-1:0] y_wide;
    logic                         y_sat;
    iirf_pkg::sample_t            y_val;
    logic                         done_load;

    // handshake
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(channel) < 32'(CHANNELS));
    assign out_free = !out_valid_reg || !out_stall;
    assign n_use    = (32'(order_reg) > 32'(MAX_ORDER)) ? iirf_pkg::ORDER_W'(MAX_ORDER)
                      : order_reg;
    assign done_load = (state_reg == S_DONE) && out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                coef_b_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                coef_a_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                iirf_pkg::CFG_ORDER: order_reg     <= cfg_data[iirf_pkg::ORDER_W-1:0];
                iirf_pkg::CFG_B0:    coef_b_reg[0] <= cfg_data;
                iirf_pkg::CFG_B1:    coef_b_reg[1] <= cfg_data;
                iirf_pkg::CFG_B2:    coef_b_reg[2] <= cfg_data;
                iirf_pkg::CFG_B3:    coef_b_reg[3] <= cfg_data;
                iirf_pkg::CFG_A1:    coef_a_reg[0] <= cfg_data;
                iirf_pkg::CFG_A2:    coef_a_reg[1] <= cfg_data;
                iirf_pkg::CFG_A3:    coef_a_reg[2] <= cfg_data;
                default:             order_reg     <= order_reg;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        n_next     = n_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_range && (command == iirf_pkg::CMD_FILTER))
                begin
                    n_next    = n_use;
                    term_next = '0;
                    pass_next = (n_use == '0);
                    state_next = (n_use == '0) ? S_DONE : S_MAC;
                end
            end
            S_MAC:
            begin
                term_next = term_reg + 1'b1;
                if (term_reg == (iirf_pkg::TERM_W'(n_reg) << 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= '0;
            n_reg     <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            n_reg     <= n_next;
            pass_reg  <= pass_next;
        end
    end

    // item payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= channel;
            x_reg  <= sample;
        end
    end

    // operand select: b0*x, then b(k)*x[n-k] and a(k)*y[n-k] in turn
    assign term_m1 = term_reg - 1'b1;
    assign tap     = term_m1[2:1];

    always_comb
    begin
        op_a = x_reg;
        op_b = coef_b_reg[0];
        mac_ctrl.sub = 1'b0;
        if (term_reg != '0)
        begin
            if (term_reg[0])
            begin
                op_a = hist_x[32'(tap)*SW +: SW];
                op_b = coef_b_reg[2'(tap + 2'd1)];
            end
            else
            begin
                op_a = hist_y[32'(tap)*SW +: SW];
                op_b = coef_a_reg[tap];
                mac_ctrl.sub = 1'b1;
            end
        end
        mac_ctrl.issue = (state_reg == S_MAC);
        mac_ctrl.first = (term_reg == '0);
    end

    iirf_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (acc)
    );

    // floor the q4.28 coefficient scale back to the sample scale and saturate to 32 bits
    always_comb
    begin
        y_wide = acc[iirf_pkg::ACC_W-1:FB];
        y_sat  = (y_wide[iirf_pkg::ACC_W-FB-1:SW-1] != '0)
                 && (y_wide[iirf_pkg::ACC_W-FB-1:SW-1] != '1);
        if (y_sat)
        begin
            y_val = y_wide[iirf_pkg::ACC_W-FB-1] ? {1'b1, {(SW-1){1'b0}}}
                    : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            y_val = y_wide[SW-1:0];
        end
    end

    // shift the used taps down by one step, new sample enters tap zero
    always_comb
    begin
        shift_x = hist_x;
        shift_y = hist_y;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if (k == 0)
            begin
                shift_x[0 +: SW] = x_reg;
                shift_y[0 +: SW] = y_val;
            end
            else if (32'(k) < 32'(n_reg))
            begin
                shift_x[k*SW +: SW] = hist_x[(k-1)*SW +: SW];
                shift_y[k*SW +: SW] = hist_y[(k-1)*SW +: SW];
            end
        end
    end

    // history write: preload at transfer, filtered row at the done step
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ch_reg[ROW_AW-1:0];
        wr_x    = shift_x;
        wr_y    = shift_y;
        priority if (accept && in_range && (command == iirf_pkg::CMD_PRELOAD))
        begin
            wr_en   = 1'b1;
            wr_addr = channel[ROW_AW-1:0];
            wr_x    = {MAX_ORDER{sample}};
            wr_y    = {MAX_ORDER{preload_output}};
        end
        else if (done_load && !pass_reg)
        begin
            wr_en = 1'b1;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    iirf_hist
    #(
        .CHANNELS  (CHANNELS),
        .MAX_ORDER (MAX_ORDER)
    )
    u_hist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_addr (channel[ROW_AW-1:0]),
        .rd_x    (hist_x),
        .rd_y    (hist_y),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_x    (wr_x),
        .wr_y    (wr_y)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_load)
        begin
            out_channel_reg <= ch_reg;
            filtered_reg    <= pass_reg ? x_reg : y_val;
            saturated_reg   <= pass_reg ? 1'b0 : y_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign filtered    = filtered_reg;
    assign saturated   = saturated_reg;

    // result register loads only from the done step
    `IIRF_ASSERT_NEXT(a_out_from_done, (state_reg != S_DONE) && !(out_valid_reg && out_stall), !out_valid_reg)
    // term counter never passes the last product of the order in use
    `IIRF_ASSERT_SAME(a_term_bound, state_reg == S_MAC, term_reg <= (iirf_pkg::TERM_W'(n_reg) << 1))
    // an in-range filter transfer always starts the sequencer
    `IIRF_ASSERT_NEXT(a_filter_starts, accept && in_range && (command == iirf_pkg::CMD_FILTER), state_reg != S_IDLE)
    // pass-through returns the sample unclipped
    `IIRF_ASSERT_NEXT(a_pass_result, done_load && pass_reg, (filtered_reg == $past(x_reg)) && !saturated_reg)

endmodule
